>>> rtl/i2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg
// shared codes, character constants and types of the integer to ascii
// formatter
// ----------------------------------------------------------------------------
package i2a_pkg;

   localparam int DIGIT_W = 4;
   localparam int CHAR_W  = 8;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [CHAR_W-1:0]  char_type;

   // action codes; full hex decodes on the high bit only
   localparam logic [1:0] ACT_DEC      = 2'd0;
   localparam logic [1:0] ACT_HEX      = 2'd1;
   localparam logic [1:0] ACT_FULL     = 2'd2;
   localparam logic [1:0] ACT_FULL_ALT = 2'd3;

   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_MINUS = 8'h2d;
   localparam char_type CH_A     = 8'h61;
   localparam char_type CH_X     = 8'h78;

   localparam digit_type DEC_RADIX = 4'd10;

   // control bundle that loads the character emitter
   typedef struct packed {
      logic       load;
      logic       skip_zeros;
      logic [1:0] pre_cnt;
      char_type   pre_first;
      char_type   pre_second;
   } emit_ctl_type;

   function automatic char_type digit_char(digit_type d);
      char_type c;
      if (d < DEC_RADIX) begin
         c = CH_ZERO + {4'd0, d};
      end else begin
         c = CH_A + {4'd0, digit_type'(d - DEC_RADIX)};
      end
      return c;
   endfunction

endpackage : i2a_pkg
`default_nettype wire

>>> rtl/i2a_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a request and response channels
// valid/ready stream interfaces; a transfer happens when both are high
// ----------------------------------------------------------------------------
interface i2a_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             action;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface : i2a_req_if

interface i2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface : i2a_rsp_if
`default_nettype wire

>>> rtl/i2a_dabble.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_dabble
// bit-serial binary to bcd converter, one input bit per cycle (shift and add 3)
// ----------------------------------------------------------------------------
module i2a_dabble
   import i2a_pkg::*;
#(
   parameter int VALUE_WIDTH = 32,
   parameter int DEC_DIGITS  = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [VALUE_WIDTH-1:0]         mag,
   output logic                                busy,
   output logic [DEC_DIGITS*DIGIT_W-1:0]       bcd
);

   localparam int BCD_W = DEC_DIGITS * DIGIT_W;
   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam digit_type ADJ_LIMIT = 4'd5;
   localparam digit_type ADJ_ADD   = 4'd3;

   logic [BCD_W-1:0]       bcd_ff, bcd_in, adj;
   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   assign busy = (cnt_ff != '0);
   assign bcd  = bcd_ff;

   // per-digit correction before each shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
         end else begin
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
         end
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      cnt_in = cnt_ff;
      if (start) begin
         bcd_in = '0;
         bin_in = mag;
         cnt_in = CNT_W'(VALUE_WIDTH);
      end else if (busy) begin
         bcd_in = {adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

endmodule : i2a_dabble
`default_nettype wire

>>> rtl/i2a_emitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_emitter
// digit shift register and output register; sends an optional prefix, drops
// leading zero digits when skip_zeros is set and sends one character per transfer
// ----------------------------------------------------------------------------
module i2a_emitter
   import i2a_pkg::*;
#(
   parameter int DEC_DIGITS = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire emit_ctl_type                          ctl,
   input  wire logic [DEC_DIGITS*DIGIT_W-1:0]         digits,
   input  wire logic [$clog2(DEC_DIGITS+1)-1:0]       count,
   output logic                                       busy,
   i2a_rsp_if.source                                  rsp
);

   localparam int DIG_W  = DEC_DIGITS * DIGIT_W;
   localparam int DCNT_W = $clog2(DEC_DIGITS + 1);

   logic [DIG_W-1:0]  dig_ff, dig_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic              skip_ff, skip_in;
   logic [1:0]        pcnt_ff, pcnt_in;
   char_type          pre0_ff, pre0_in, pre1_ff, pre1_in;
   logic              ovalid_ff, ovalid_in;
   char_type          ochar_ff, ochar_in;
   logic              olast_ff, olast_in;

   logic      out_free;
   logic      skipping;
   digit_type top_d;

   assign out_free = !ovalid_ff || rsp.ready;
   assign top_d    = dig_ff[DIG_W-1 -: DIGIT_W];
   assign skipping = skip_ff && (top_d == '0) && (dcnt_ff > DCNT_W'(1));
   assign busy     = (pcnt_ff != '0) || (dcnt_ff != '0);

   assign rsp.valid     = ovalid_ff;
   assign rsp.character = ochar_ff;
   assign rsp.last      = olast_ff;

   always_comb begin
      dig_in    = dig_ff;
      dcnt_in   = dcnt_ff;
      skip_in   = skip_ff;
      pcnt_in   = pcnt_ff;
      pre0_in   = pre0_ff;
      pre1_in   = pre1_ff;
      ovalid_in = ovalid_ff && !rsp.ready;
      ochar_in  = ochar_ff;
      olast_in  = olast_ff;

      // prefix characters go first, digits always follow them
      if (pcnt_ff != '0 && out_free) begin
         ovalid_in = 1'b1;
         ochar_in  = pre0_ff;
         olast_in  = 1'b0;
         pre0_in   = pre1_ff;
         pcnt_in   = pcnt_ff - 2'd1;
      end

      // leading zeros drop without using the output
      if (skipping) begin
         dig_in  = dig_ff << DIGIT_W;
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end else if (pcnt_ff == '0 && dcnt_ff != '0 && out_free) begin
         ovalid_in = 1'b1;
         ochar_in  = digit_char(top_d);
         olast_in  = (dcnt_ff == DCNT_W'(1));
         dig_in    = dig_ff << DIGIT_W;
         dcnt_in   = dcnt_ff - DCNT_W'(1);
         // zeros after the first digit sent are part of the number
         skip_in   = 1'b0;
      end

      if (ctl.load) begin
         dig_in  = digits;
         dcnt_in = count;
         skip_in = ctl.skip_zeros;
         pcnt_in = ctl.pre_cnt;
         pre0_in = ctl.pre_first;
         pre1_in = ctl.pre_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff   <= '0;
         pcnt_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         dcnt_ff   <= dcnt_in;
         pcnt_ff   <= pcnt_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff   <= dig_in;
      skip_ff  <= skip_in;
      pre0_ff  <= pre0_in;
      pre1_ff  <= pre1_in;
      ochar_ff <= ochar_in;
      olast_ff <= olast_in;
   end

endmodule : i2a_emitter
`default_nettype wire

>>> rtl/integer_to_ascii_formatter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// prints a word as ascii text, one character per response transfer
// ----------------------------------------------------------------------------
// Takes one word and an action per request transfer and returns its text one
// character per response transfer, most significant character first, with
// last set on the final one. Action 0 gives signed decimal (leading minus, no
// leading zeros, the most negative value printed from its unsigned
// magnitude), action 1 lowercase hex with no leading zeros, actions 2 and 3
// "0x" plus every hex digit of the word. One request is in work at a time.
// Decimal runs the magnitude through the bit-serial bcd converter, then loads
// every digit position of the bcd register (DEC_DIGITS, 10 at width 32) into
// the emitter, leading zeros dropping one per cycle and each character leaving
// when the sink is ready, before going back to idle. Hex skips the converter and
// loads the emitter at the request transfer. The last character of a text
// sits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top
   import i2a_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   i2a_req_if.sink    req_bus,
   i2a_rsp_if.source  rsp_bus
);

   // decimal digits of the largest unsigned word: floor(w * log10 2) + 1
   localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
   localparam int DIG_W      = DEC_DIGITS * DIGIT_W;
   localparam int HEX_W      = HEX_DIGITS * DIGIT_W;
   localparam int DCNT_W     = $clog2(DEC_DIGITS + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CONV = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      neg_ff, neg_in;

   logic                   accept;
   logic                   is_dec, is_full;
   logic                   neg;
   logic [VALUE_WIDTH-1:0] mag;
   logic [HEX_W-1:0]       hex_pad;
   logic [DIG_W-1:0]       hex_load;

   logic                   dab_start, dab_busy;
   logic [DIG_W-1:0]       bcd;

   emit_ctl_type           ectl;
   logic [DIG_W-1:0]       emit_digits;
   logic [DCNT_W-1:0]      emit_count;
   logic                   emit_busy;

   // requests are taken only between texts
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // action decode
   always_comb begin
      is_dec  = 1'b0;
      is_full = 1'b0;
      unique case (req_bus.action) inside
         ACT_DEC:                is_dec  = 1'b1;
         ACT_HEX:                is_full = 1'b0;
         ACT_FULL, ACT_FULL_ALT: is_full = 1'b1;
      endcase
   end

   // two's complement magnitude; the most negative value maps to itself,
   // which read unsigned is the right magnitude
   assign neg = req_bus.value[VALUE_WIDTH-1];
   assign mag = neg ? (~req_bus.value + VALUE_WIDTH'(1)) : req_bus.value;

   // hex nibbles, most significant digit at the top of the digit register
   assign hex_pad  = HEX_W'(req_bus.value);
   assign hex_load = DIG_W'(hex_pad) << (DIG_W - HEX_W);

   assign dab_start = accept && is_dec;

   i2a_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DEC_DIGITS  (DEC_DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .start (dab_start),
      .mag   (mag),
      .busy  (dab_busy),
      .bcd   (bcd)
   );

   // emitter loading: hex right at the request transfer, decimal once the
   // converter has shifted the whole magnitude in
   always_comb begin
      ectl.load       = 1'b0;
      ectl.skip_zeros = 1'b1;
      ectl.pre_cnt    = 2'd0;
      ectl.pre_first  = CH_MINUS;
      ectl.pre_second = CH_X;
      emit_digits     = bcd;
      emit_count      = DCNT_W'(DEC_DIGITS);
      if (state_ff == S_IDLE && accept && !is_dec) begin
         ectl.load   = 1'b1;
         emit_digits = hex_load;
         emit_count  = DCNT_W'(HEX_DIGITS);
         if (is_full) begin
            ectl.skip_zeros = 1'b0;
            ectl.pre_cnt    = 2'd2;
            ectl.pre_first  = CH_ZERO;
         end
      end else if (state_ff == S_CONV && !dab_busy) begin
         ectl.load    = 1'b1;
         ectl.pre_cnt = neg_ff ? 2'd1 : 2'd0;
      end
   end

   i2a_emitter #(
      .DEC_DIGITS (DEC_DIGITS)
   ) u_emitter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ectl),
      .digits (emit_digits),
      .count  (emit_count),
      .busy   (emit_busy),
      .rsp    (rsp_bus)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               neg_in   = neg;
               state_in = is_dec ? S_CONV : S_EMIT;
            end
         end
         S_CONV: begin
            if (!dab_busy) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!emit_busy) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
   end

   // the emitter has finished its text whenever new requests are taken
   a_idle_emitter_done : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !emit_busy)
      else $error("emitter still busy while taking requests");

   // the converter runs only during the conversion phase
   a_dabble_in_conv : assert property (@(posedge clock) disable iff (reset)
      dab_busy |-> (state_ff == S_CONV))
      else $error("bcd converter running outside conversion");

   // a decimal request always goes through the converter before any output
   a_dec_converts : assert property (@(posedge clock) disable iff (reset)
      dab_start |=> dab_busy && (state_ff == S_CONV))
      else $error("decimal request did not start conversion");

   // every character sent is a nonzero code, never an unloaded register
   a_char_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.character != 8'd0))
      else $error("null character on response");

endmodule : integer_to_ascii_formatter_top
`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench for integer_to_ascii_formatter_top
// feeds words with every action code through the request channel, predicts the
// text of each one and checks every character transfer in order, with random
// idle cycles on both channels
// ----------------------------------------------------------------------------
module testbench;
   import i2a_pkg::*;

   localparam int VALUE_WIDTH      = 32;
   localparam int HEX_DIGITS       = (VALUE_WIDTH + 3) / 4;
   localparam int MAX_IDLE         = 10;
   localparam int RANDOM_PER_PHASE = 85;
   localparam int SETTLE_CYCLES    = 60;
   // slowest text is 11 characters, each of them may wait out a full stall
   localparam int CYCLE_LIMIT      = 400000;
   localparam int REPORT_LINES     = 40;

   typedef logic [VALUE_WIDTH-1:0] word_type;
   typedef char_type text_type[$];

   typedef struct packed {
      char_type character;
      logic     last;
   } glyph_type;

   // -------------------------------------------------------------------------
   // scoreboard: spells each accepted word and keeps its characters in order
   // -------------------------------------------------------------------------
   class text_scoreboard;
      glyph_type due_glyphs[$];
      int        error_count;

      function new();
         error_count = 0;
      endfunction

      static function char_type hex_glyph(digit_type nibble);
         if (nibble < 4'd10) begin
            return CH_ZERO + char_type'(nibble);
         end
         return CH_A + char_type'(digit_type'(nibble - 4'd10));
      endfunction

      // text of one word, most significant character first
      function text_type spell_word(logic [1:0] action, word_type word);
         text_type text;
         text_type digits;
         word_type magnitude;
         if (action == ACT_FULL || action == ACT_FULL_ALT) begin
            text.push_back(CH_ZERO);
            text.push_back(CH_X);
            for (int i = HEX_DIGITS - 1; i >= 0; i--) begin
               text.push_back(hex_glyph(word[4*i +: 4]));
            end
            return text;
         end
         magnitude = word;
         if (action == ACT_DEC) begin
            // magnitude taken unsigned, so the most negative word survives
            if (word[VALUE_WIDTH-1]) begin
               text.push_back(CH_MINUS);
               magnitude = -word;
            end
            do begin
               digits.push_front(CH_ZERO + char_type'(magnitude % 10));
               magnitude = magnitude / 10;
            end while (magnitude != 0);
         end else begin
            do begin
               digits.push_front(hex_glyph(magnitude[3:0]));
               magnitude = magnitude >> 4;
            end while (magnitude != 0);
         end
         while (digits.size() != 0) begin
            text.push_back(digits.pop_front());
         end
         return text;
      endfunction

      task report(string msg);
         if (error_count < REPORT_LINES) begin
            $display("mismatch: %s", msg);
         end
         error_count++;
      endtask

      function void note_request(logic [1:0] action, word_type word);
         text_type  text;
         glyph_type glyph;
         text = spell_word(action, word);
         foreach (text[k]) begin
            glyph.character = text[k];
            glyph.last      = (k == text.size() - 1);
            due_glyphs.push_back(glyph);
         end
      endfunction

      task check_char(char_type character, logic last);
         glyph_type due;
         if (due_glyphs.size() == 0) begin
            report($sformatf("character 8'h%02h last %0b with none due", character, last));
            return;
         end
         due = due_glyphs.pop_front();
         if (character !== due.character) begin
            report($sformatf("character 8'h%02h, due 8'h%02h", character, due.character));
         end
         if (last !== due.last) begin
            report($sformatf("last %0b, due %0b on 8'h%02h", last, due.last, due.character));
         end
      endtask

      task drain_check();
         if (due_glyphs.size() != 0) begin
            report($sformatf("%0d characters never came", due_glyphs.size()));
         end
      endtask
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and the block
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;
   int   cycle_count = 0;

   // idle switches per phase; cleared they give stretches of back to back work
   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;

   text_scoreboard scoreboard;

   i2a_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_bus ();
   i2a_rsp_if                             rsp_bus ();

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   integer_to_ascii_formatter_top #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL integer_to_ascii_formatter_top");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------

   // one request transfer; valid stays high into the next call when no gap is
   // drawn, so back to back transfers never drop valid within a step
   task automatic send_request(logic [1:0] action, word_type word);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.action <= action;
      req_bus.value  <= word;
      do @(posedge clock); while (!req_bus.ready);
      scoreboard.note_request(action, word);
   endtask

   // sender holds off until every predicted character has come out
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (scoreboard.due_glyphs.size() != 0);
   endtask

   // decimal gets the most weight, the alternate full hex code the least
   function automatic logic [1:0] pick_action();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return ACT_DEC;
      if (roll < 7) return ACT_HEX;
      if (roll < 9) return ACT_FULL;
      return ACT_FULL_ALT;
   endfunction

   // words spread over every text length, sign and extreme
   function automatic word_type pick_word();
      word_type word;
      case ($urandom_range(0, 5))
         0: word = $urandom();
         1: word = $urandom_range(0, 99);
         2: word = -word_type'($urandom_range(1, 99));
         3: word = word_type'($urandom()) >> $urandom_range(0, VALUE_WIDTH - 1);
         4: begin
            case ($urandom_range(0, 4))
               0: word = '0;
               1: word = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
               2: word = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
               3: word = '1;
               default: word = {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1};
            endcase
         end
         default: word = -(word_type'($urandom()) >> $urandom_range(0, VALUE_WIDTH - 1));
      endcase
      return word;
   endfunction

   initial begin
      scoreboard     = new();
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.action = ACT_DEC;
      req_bus.value  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, single digits, digit carry, largest, most negative and other negatives
      send_request(ACT_DEC, 32'd0);
      send_request(ACT_DEC, 32'd1);
      send_request(ACT_DEC, 32'd9);
      send_request(ACT_DEC, 32'd10);
      send_request(ACT_DEC, 32'h7fffffff);
      send_request(ACT_DEC, 32'h80000000);
      send_request(ACT_DEC, 32'h80000001);
      send_request(ACT_DEC, 32'hffffffff);
      send_request(ACT_DEC, 32'hfffffff6);
      // minimal hex: zero, one nibble, nibble carry, full width
      send_request(ACT_HEX, 32'd0);
      send_request(ACT_HEX, 32'd1);
      send_request(ACT_HEX, 32'h0000000f);
      send_request(ACT_HEX, 32'h00000010);
      send_request(ACT_HEX, 32'h00abcdef);
      send_request(ACT_HEX, 32'h80000000);
      send_request(ACT_HEX, 32'hffffffff);
      // full hex keeps leading zeros; action three must match action two
      send_request(ACT_FULL, 32'd0);
      send_request(ACT_FULL, 32'hffffffff);
      send_request(ACT_FULL, 32'h0123abcd);
      send_request(ACT_FULL_ALT, 32'h89abcdef);
      send_request(ACT_FULL_ALT, 32'd0);
      hold_until_drained();

      // random phases: both sides idle, sender only, receiver only, neither
      for (int phase = 0; phase < 4; phase++) begin
         send_idle = (phase == 0 || phase == 1);
         recv_idle = (phase == 0 || phase == 2);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request(pick_action(), pick_word());
         end
         hold_until_drained();
      end

      // catch any stray character after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);
      scoreboard.drain_check();
      if (scoreboard.error_count == 0) begin
         $display("PASS integer_to_ascii_formatter_top");
      end else begin
         $display("FAIL integer_to_ascii_formatter_top");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // response side
   // -------------------------------------------------------------------------

   // ready drops for a random stall before each character transfer; with no
   // stall it stays high across transfers
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         scoreboard.check_char(rsp_bus.character, rsp_bus.last);
      end
   end

endmodule : testbench
